>>> rtl/qscf_pkg.sv
// qscf_pkg: shared widths, latencies and payload types for the quintic segment fit unit
// no dependencies; used by every file under rtl except qscf_delay and qscf_mul
package qscf_pkg;

  // field widths
  localparam int TW    = 32;          // q16.16 input fields
  localparam int CW    = 64;          // q32.32 coefficients
  localparam int MIN_W = 16;          // minimum interval register

  // numerator term widths: n = (c2 * t + c1 * 2^16) * t + c0 * 2^32
  localparam int C2W = 36;
  localparam int C1W = 38;
  localparam int C0W = 39;
  localparam int UW  = 69;            // inner horner sum
  localparam int NW  = UW + 32;       // full numerator, signed
  localparam int MW  = NW - 1;        // numerator magnitude

  // quotient bits kept by the dividers, one per divider stage
  localparam int QW = 64;

  // pipeline timing, counted from the coefficient stage
  localparam int MUL_LAT  = 2;
  localparam int DIV_LAT  = QW + 1;
  localparam int T_ABS    = 2 * MUL_LAT + 3;
  localparam int T_DIV    = 4 * MUL_LAT;
  localparam int SIDE_LAT = T_DIV + DIV_LAT;

  // fixed-point alignment shift of each upper coefficient
  localparam int SH3 = 31;
  localparam int SH4 = 47;
  localparam int SH5 = 63;

  // terms whose quotient sign is flipped (cubic and quintic)
  localparam logic [2:0] NEGATE = 3'b101;

  typedef struct packed {
    logic        [TW-1:0] duration;
    logic signed [TW-1:0] start_pos;
    logic signed [TW-1:0] start_vel;
    logic signed [TW-1:0] start_acc;
    logic signed [TW-1:0] end_pos;
    logic signed [TW-1:0] end_vel;
    logic signed [TW-1:0] end_acc;
  } seg_in_t;

  typedef struct packed {
    logic signed [CW-1:0] coef0;
    logic signed [CW-1:0] coef1;
    logic signed [CW-1:0] coef2;
    logic signed [CW-1:0] coef3;
    logic signed [CW-1:0] coef4;
    logic signed [CW-1:0] coef5;
    logic                 interval_invalid;
    logic                 saturated;
  } seg_out_t;

endpackage

>>> rtl/qscf_delay.sv
// qscf_delay: enabled shift line that keeps side data in step with the datapath
// no package dependencies
module qscf_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[DEPTH-1];

endmodule

>>> rtl/qscf_mul.sv
// qscf_mul: two-stage signed-by-unsigned multiplier built from 32x32 partial products
// no package dependencies
module qscf_mul #(
  parameter int AW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic        [31:0]   b,
  output logic signed [AW+31:0] p
);

  localparam int NL = (AW + 31) / 32;
  localparam int PW = AW + 32;

  logic signed [NL*32-1:0] a_ext;
  logic signed [32:0]      bs;
  logic        [63:0]      pp [NL];
  logic        [PW-1:0]    acc;
  logic        [PW-1:0]    ext;

  assign a_ext = (NL*32)'(a);
  assign bs    = {1'b0, b};

  // stage 1: one partial product per 32-bit limb, top limb signed
  for (genvar g = 0; g < NL; g++) begin : g_pp
    logic signed [32:0] as;
    logic signed [65:0] pr;
    assign as = {(g == NL - 1) ? a_ext[32*g+31] : 1'b0, a_ext[32*g +: 32]};
    assign pr = as * bs;
    always_ff @(posedge clk) begin
      if (en) begin
        pp[g] <= pr[63:0];
      end
    end
  end

  // stage 2: shifted sum of the limbs
  always_comb begin
    acc = '0;
    ext = '0;
    for (int i = 0; i < NL; i++) begin
      if (i == NL - 1) begin
        ext = PW'($signed(pp[i]));
      end else begin
        ext = PW'(pp[i]);
      end
      acc = acc + (ext << (32 * i));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= acc;
    end
  end

endmodule

>>> rtl/qscf_div.sv
// qscf_div: pipelined restoring divider, one quotient bit per stage, with overflow check
// depends on qscf_pkg for the quotient width
module qscf_div #(
  parameter int DW = 96,
  parameter int HW = 67
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [HW-1:0]             num_hi,
  input  logic [qscf_pkg::QW-1:0]   num_lo,
  input  logic [DW-1:0]             den,
  input  logic                      neg,
  output logic [qscf_pkg::QW-1:0]   quo,
  output logic                      ovf,
  output logic                      neg_o
);

  localparam int QW = qscf_pkg::QW;

  logic [DW-1:0] rem_s [QW+1];
  logic [DW-1:0] den_s [QW+1];
  logic [QW-1:0] lo_s  [QW+1];
  logic [QW-1:0] quo_s [QW+1];
  logic          ovf_s [QW+1];
  logic          neg_s [QW+1];

  // entry stage: upper dividend part at or above the divisor means a quotient wider than 64 bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_s[0] <= DW'(num_hi);
      den_s[0] <= den;
      lo_s[0]  <= num_lo;
      quo_s[0] <= '0;
      ovf_s[0] <= (DW'(num_hi) >= den);
      neg_s[0] <= neg;
    end
  end

  for (genvar g = 0; g < QW; g++) begin : g_step
    logic [DW:0]   shf;
    logic [DW+1:0] dif;
    logic          ge;
    assign shf = {rem_s[g], lo_s[g][QW-1]};
    assign dif = {1'b0, shf} - {2'b00, den_s[g]};
    assign ge  = ~dif[DW+1];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_s[g+1] <= ge ? dif[DW-1:0] : shf[DW-1:0];
        den_s[g+1] <= den_s[g];
        lo_s[g+1]  <= {lo_s[g][QW-2:0], 1'b0};
        quo_s[g+1] <= {quo_s[g][QW-2:0], ge};
        ovf_s[g+1] <= ovf_s[g];
        neg_s[g+1] <= neg_s[g];
      end
    end
  end

  assign quo   = quo_s[QW];
  assign ovf   = ovf_s[QW];
  assign neg_o = neg_s[QW];

endmodule

>>> rtl/quintic_segment_coefficient_fit_unit.sv
// quintic_segment_coefficient_fit_unit: top level of the quintic segment fit
// depends on qscf_pkg, qscf_mul, qscf_div and qscf_delay
//
// Takes one segment per transfer (duration and the position, velocity and
// acceleration at both ends, all q16.16) and returns the six q32.32
// coefficients of the quintic that meets those end conditions. The block is
// a single deep pipeline: while the skid entry is empty it takes a new segment
// every cycle and returns one result per cycle. Most of its depth lies in the
// three 65-stage restoring dividers (one quotient bit per stage) that form the
// cubic, quartic and quintic terms; the powers of t and the numerators come
// from 32x32 multiplier stages ahead of them. The upper coefficients truncate
// toward zero and saturate to the 64-bit range, with saturated raised. A
// segment whose duration is at or below min_interval returns zero coefficients
// with interval_invalid set. min_interval is written through cfg_we/cfg_data
// and must only change while no segment is in flight. An output register plus
// one skid entry let the block take another segment while a result waits;
// in_ready drops only once that skid entry is occupied.
module quintic_segment_coefficient_fit_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  qscf_pkg::seg_in_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output qscf_pkg::seg_out_t           out_data,
  input  logic                         cfg_we,
  input  logic [qscf_pkg::MIN_W-1:0]   cfg_data
);

  localparam int TW      = qscf_pkg::TW;
  localparam int CW      = qscf_pkg::CW;
  localparam int C2W     = qscf_pkg::C2W;
  localparam int C1W     = qscf_pkg::C1W;
  localparam int C0W     = qscf_pkg::C0W;
  localparam int UW      = qscf_pkg::UW;
  localparam int NW      = qscf_pkg::NW;
  localparam int MW      = qscf_pkg::MW;
  localparam int QW      = qscf_pkg::QW;
  localparam int MUL_LAT = qscf_pkg::MUL_LAT;
  localparam int SH3     = qscf_pkg::SH3;
  localparam int SH4     = qscf_pkg::SH4;
  localparam int SH5     = qscf_pkg::SH5;
  localparam int SIDE_LAT_W = qscf_pkg::SIDE_LAT;

  // per-segment data that rides alongside the arithmetic
  typedef struct packed {
    logic                 inv;
    logic signed [TW-1:0] pos;
    logic signed [TW-1:0] vel;
    logic signed [TW-1:0] acc;
  } side_t;

  // global advance: the whole pipe moves unless the skid entry is holding a result
  logic en;

  // config register
  logic [qscf_pkg::MIN_W-1:0] min_interval;

  // input register
  logic               a_valid;
  qscf_pkg::seg_in_t  a_data;

  // coefficient stage
  logic                  b_valid;
  logic [TW-1:0]         b_t;
  side_t                 b_side;
  logic signed [C2W-1:0] c2_n [3];
  logic signed [C1W-1:0] c1_n [3];
  logic signed [C0W-1:0] c0_n [3];
  logic signed [C2W-1:0] c2_b [3];
  logic signed [C1W-1:0] c1_b [3];
  logic signed [C0W-1:0] c0_b [3];
  logic signed [C0W-1:0] d_pos;
  logic signed [C1W-1:0] v1e;
  logic signed [C1W-1:0] v2e;
  logic signed [C2W-1:0] a1e;
  logic signed [C2W-1:0] a2e;

  // powers of t
  logic signed [TW+32:0]   t2p;
  logic signed [2*TW+32:0] t3p;
  logic signed [3*TW+32:0] t4p;
  logic signed [4*TW+32:0] t5p;
  logic [TW-1:0]   t_d2;
  logic [TW-1:0]   t_d3;
  logic [TW-1:0]   t_d4;
  logic [TW-1:0]   t_d6;
  logic [3*TW-1:0] den3;
  logic [4*TW-1:0] den4;

  // numerator magnitudes at the divider inputs
  logic [MW-1:0] div_mag [3];
  logic          div_neg [3];

  // divider results
  logic [QW-1:0] dq   [3];
  logic          dovf [3];
  logic          dneg [3];

  // result assembly
  logic [SIDE_LAT_W-1:0] vpipe;
  side_t                 side_q;
  logic [2:0]            clip;
  logic [QW-1:0]         val [3];
  logic                  p_valid;
  qscf_pkg::seg_out_t    p_data;

  // output register and skid entry
  logic                  skid_valid;
  qscf_pkg::seg_out_t    skid_data;

  assign en       = ~skid_valid;
  assign in_ready = en;

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= '0;
    end else if (cfg_we) begin
      min_interval <= cfg_data;
    end
  end

  // ---------------------------------------------------------------- input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_data <= in_data;
    end
  end

  // ---------------------------------------------------------------- boundary coefficients
  // each upper term is n = c2 * t^2 + c1 * t * 2^16 + c0 * 2^32
  always_comb begin
    d_pos = C0W'(a_data.start_pos) - C0W'(a_data.end_pos);
    v1e   = C1W'(a_data.start_vel);
    v2e   = C1W'(a_data.end_vel);
    a1e   = C2W'(a_data.start_acc);
    a2e   = C2W'(a_data.end_acc);
    // cubic
    c2_n[0] = 3 * a1e - a2e;
    c1_n[0] = 8 * v2e + 12 * v1e;
    c0_n[0] = 20 * d_pos;
    // quartic
    c2_n[1] = 3 * a1e - 2 * a2e;
    c1_n[1] = 14 * v2e + 16 * v1e;
    c0_n[1] = 30 * d_pos;
    // quintic
    c2_n[2] = a1e - a2e;
    c1_n[2] = 6 * v2e + 6 * v1e;
    c0_n[2] = 12 * d_pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_t        <= a_data.duration;
      // a zero duration always lands here, so the dividers never see t = 0 unmasked
      b_side.inv <= (a_data.duration <= TW'(min_interval));
      b_side.pos <= a_data.start_pos;
      b_side.vel <= a_data.start_vel;
      b_side.acc <= a_data.start_acc;
      for (int i = 0; i < 3; i++) begin
        c2_b[i] <= c2_n[i];
        c1_b[i] <= c1_n[i];
        c0_b[i] <= c0_n[i];
      end
    end
  end

  // ---------------------------------------------------------------- powers of t
  // t^2, t^3, t^4, t^5 one after another, each from its own multiplier
  qscf_mul #(.AW(TW + 1)) u_mul_t2 (
    .clk (clk), .en (en), .a ({1'b0, b_t}), .b (b_t), .p (t2p)
  );

  qscf_delay #(.W(TW), .DEPTH(MUL_LAT)) u_dly_t2 (
    .clk (clk), .en (en), .d (b_t), .q (t_d2)
  );

  qscf_mul #(.AW(2 * TW + 1)) u_mul_t3 (
    .clk (clk), .en (en), .a ({1'b0, t2p[2*TW-1:0]}), .b (t_d2), .p (t3p)
  );

  qscf_delay #(.W(TW), .DEPTH(2 * MUL_LAT)) u_dly_t4 (
    .clk (clk), .en (en), .d (b_t), .q (t_d4)
  );

  qscf_mul #(.AW(3 * TW + 1)) u_mul_t4 (
    .clk (clk), .en (en), .a ({1'b0, t3p[3*TW-1:0]}), .b (t_d4), .p (t4p)
  );

  qscf_delay #(.W(TW), .DEPTH(3 * MUL_LAT)) u_dly_t6 (
    .clk (clk), .en (en), .d (b_t), .q (t_d6)
  );

  qscf_mul #(.AW(4 * TW + 1)) u_mul_t5 (
    .clk (clk), .en (en), .a ({1'b0, t4p[4*TW-1:0]}), .b (t_d6), .p (t5p)
  );

  // t for the outer horner multiply
  qscf_delay #(.W(TW), .DEPTH(MUL_LAT + 1)) u_dly_t3 (
    .clk (clk), .en (en), .d (b_t), .q (t_d3)
  );

  // line the lower powers up with t^5 at the divider inputs
  qscf_delay #(.W(3 * TW), .DEPTH(qscf_pkg::T_DIV - 2 * MUL_LAT)) u_dly_den3 (
    .clk (clk), .en (en), .d (t3p[3*TW-1:0]), .q (den3)
  );

  qscf_delay #(.W(4 * TW), .DEPTH(qscf_pkg::T_DIV - 3 * MUL_LAT)) u_dly_den4 (
    .clk (clk), .en (en), .d (t4p[4*TW-1:0]), .q (den4)
  );

  // ---------------------------------------------------------------- numerators
  for (genvar g = 0; g < 3; g++) begin : g_num
    logic signed [C2W+31:0] up;
    logic signed [C1W-1:0]  c1d;
    logic signed [UW-1:0]   u_r;
    logic signed [NW-1:0]   np;
    logic signed [C0W-1:0]  c0d;
    logic signed [NW-1:0]   n_r;
    logic signed [NW-1:0]   n_neg;
    logic        [MW-1:0]   mag_r;
    logic                   neg_r;

    // inner horner step: c2 * t + c1 * 2^16
    qscf_mul #(.AW(C2W)) u_mul_u (
      .clk (clk), .en (en), .a (c2_b[g]), .b (b_t), .p (up)
    );

    qscf_delay #(.W(C1W), .DEPTH(MUL_LAT)) u_dly_c1 (
      .clk (clk), .en (en), .d (c1_b[g]), .q (c1d)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        u_r <= UW'(up) + (UW'(c1d) <<< 16);
      end
    end

    // outer horner step: u * t + c0 * 2^32
    qscf_mul #(.AW(UW)) u_mul_n (
      .clk (clk), .en (en), .a (u_r), .b (t_d3), .p (np)
    );

    qscf_delay #(.W(C0W), .DEPTH(2 * MUL_LAT + 1)) u_dly_c0 (
      .clk (clk), .en (en), .d (c0_b[g]), .q (c0d)
    );

    always_ff @(posedge clk) begin
      if (en) begin
        n_r <= np + (NW'(c0d) <<< 32);
      end
    end

    // sign and magnitude, with the term's own sign flip folded in
    assign n_neg = -n_r;

    always_ff @(posedge clk) begin
      if (en) begin
        mag_r <= n_r[NW-1] ? n_neg[MW-1:0] : n_r[MW-1:0];
        neg_r <= n_r[NW-1] ^ qscf_pkg::NEGATE[g];
      end
    end

    qscf_delay #(.W(MW + 1), .DEPTH(qscf_pkg::T_DIV - qscf_pkg::T_ABS)) u_dly_mag (
      .clk (clk), .en (en), .d ({neg_r, mag_r}), .q ({div_neg[g], div_mag[g]})
    );
  end

  // ---------------------------------------------------------------- dividers
  // dividend is |n| shifted left by the term's alignment; the part above bit 63
  // enters as the starting remainder, the low 64 bits shift in one per stage
  qscf_div #(.DW(3 * TW), .HW(MW - QW + SH3)) u_div3 (
    .clk    (clk),
    .en     (en),
    .num_hi (div_mag[0][MW-1:QW-SH3]),
    .num_lo ({div_mag[0][QW-SH3-1:0], {SH3{1'b0}}}),
    .den    (den3),
    .neg    (div_neg[0]),
    .quo    (dq[0]),
    .ovf    (dovf[0]),
    .neg_o  (dneg[0])
  );

  qscf_div #(.DW(4 * TW), .HW(MW - QW + SH4)) u_div4 (
    .clk    (clk),
    .en     (en),
    .num_hi (div_mag[1][MW-1:QW-SH4]),
    .num_lo ({div_mag[1][QW-SH4-1:0], {SH4{1'b0}}}),
    .den    (den4),
    .neg    (div_neg[1]),
    .quo    (dq[1]),
    .ovf    (dovf[1]),
    .neg_o  (dneg[1])
  );

  qscf_div #(.DW(5 * TW), .HW(MW - QW + SH5)) u_div5 (
    .clk    (clk),
    .en     (en),
    .num_hi (div_mag[2][MW-1:QW-SH5]),
    .num_lo ({div_mag[2][QW-SH5-1:0], {SH5{1'b0}}}),
    .den    (t5p[5*TW-1:0]),
    .neg    (div_neg[2]),
    .quo    (dq[2]),
    .ovf    (dovf[2]),
    .neg_o  (dneg[2])
  );

  // ---------------------------------------------------------------- side data and valid
  qscf_delay #(.W($bits(side_t)), .DEPTH(SIDE_LAT_W)) u_dly_side (
    .clk (clk), .en (en), .d (b_side), .q (side_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[SIDE_LAT_W-2:0], b_valid};
    end
  end

  assign p_valid = vpipe[SIDE_LAT_W-1];

  // ---------------------------------------------------------------- saturation and sign
  for (genvar g = 0; g < 3; g++) begin : g_sat
    logic [QW-1:0] magsat;
    // negative results may reach 2^63, positive ones stop at 2^63 - 1
    assign clip[g] = dovf[g] | (dq[g][QW-1] & (~dneg[g] | (|dq[g][QW-2:0])));
    assign magsat  = clip[g] ? (dneg[g] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}})
                             : dq[g];
    assign val[g]  = dneg[g] ? -magsat : magsat;
  end

  always_comb begin
    p_data = '0;
    if (side_q.inv) begin
      p_data.interval_invalid = 1'b1;
    end else begin
      p_data.coef0     = CW'(side_q.pos) <<< 16;
      p_data.coef1     = CW'(side_q.vel) <<< 16;
      p_data.coef2     = CW'(side_q.acc) <<< 15;
      p_data.coef3     = val[0];
      p_data.coef4     = val[1];
      p_data.coef5     = val[2];
      p_data.saturated = |clip;
    end
  end

  // ---------------------------------------------------------------- output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      // result held; a result leaving the pipe now parks in the skid entry
      if (en && p_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (en && p_valid) begin
        skid_data <= p_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else begin
      out_data <= p_data;
    end
  end

endmodule

>>> rtl/qscf_checker.sv
// qscf_checker: port-level checks for the quintic segment fit unit, bound to the top level
// depends on qscf_pkg for the payload types
module qscf_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input qscf_pkg::seg_out_t           out_data
);

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present right after reset");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  // rejected segments carry zero coefficients and no saturation
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.interval_invalid |->
      out_data.coef0 == '0 && out_data.coef1 == '0 && out_data.coef2 == '0 &&
      out_data.coef3 == '0 && out_data.coef4 == '0 && out_data.coef5 == '0 &&
      !out_data.saturated)
    else $error("invalid interval with nonzero result");

  // lower coefficients are plain rescaled inputs
  a_low_format: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.coef0[15:0] == '0 && out_data.coef1[15:0] == '0 &&
      out_data.coef2[14:0] == '0)
    else $error("lower coefficient has stray fraction bits");

  // back-pressure at the input only follows a stalled output
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

endmodule

bind quintic_segment_coefficient_fit_unit qscf_checker u_qscf_checker (.*);

>>> bench/qscf_fit_checker.sv
// qscf_fit_checker: watches the segment and coefficient channels of the quintic fit unit,
// predicts every result with wide exact arithmetic and compares it field by field
// depends on qscf_pkg
`timescale 1ns / 100ps

module qscf_fit_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  qscf_pkg::seg_in_t          in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  qscf_pkg::seg_out_t         out_data,
  input  logic                       cfg_we,
  input  logic [qscf_pkg::MIN_W-1:0] cfg_data,
  output int                         errors,
  output int                         pending,
  output int                         n_segments,
  output int                         n_invalid,
  output int                         n_saturated
);

  typedef logic signed [255:0] wide_t;

  logic [qscf_pkg::MIN_W-1:0] min_interval;
  qscf_pkg::seg_out_t         coef_queue[$];

  // sign * num * 2^shift / t^power, truncated toward zero, clipped to 64 bits
  function automatic logic [63:0] fit_quotient(wide_t num, bit flip, int shift, int power,
                                               wide_t t, ref bit sat);
    logic [255:0] den, mag, q, lim;
    bit neg;
    den = 1;
    for (int i = 0; i < power; i++) den = den * t;
    neg = num < 0;
    mag = neg ? -num : num;
    mag = mag << shift;
    q = mag / den;
    neg = neg ^ flip;
    lim = neg ? 256'h8000000000000000 : 256'h7FFFFFFFFFFFFFFF;
    if (q > lim) begin
      q = lim;
      sat = 1;
    end
    return neg ? -q[63:0] : q[63:0];
  endfunction

  // c2 * t^2 + c1 * t * 2^16 + c0 * 2^32
  function automatic wide_t fit_numerator(wide_t c2, wide_t c1, wide_t c0, wide_t t);
    return c2 * t * t + ((c1 * t) <<< 16) + (c0 <<< 32);
  endfunction

  function automatic qscf_pkg::seg_out_t fit_segment(qscf_pkg::seg_in_t s,
                                                     logic [qscf_pkg::MIN_W-1:0] min_iv);
    qscf_pkg::seg_out_t r;
    wide_t t, p1, v1, a1, p2, v2, a2, w;
    bit sat;
    r = '0;
    sat = 0;
    t = $signed({224'b0, s.duration});
    p1 = s.start_pos; v1 = s.start_vel; a1 = s.start_acc;
    p2 = s.end_pos;   v2 = s.end_vel;   a2 = s.end_acc;
    if (s.duration <= {16'b0, min_iv}) begin
      r.interval_invalid = 1;
      return r;
    end
    w = p1 <<< 16; r.coef0 = w[63:0];
    w = v1 <<< 16; r.coef1 = w[63:0];
    w = a1 <<< 15; r.coef2 = w[63:0];
    r.coef3 = fit_quotient(fit_numerator(3 * a1 - a2, 8 * v2 + 12 * v1, 20 * (p1 - p2), t),
                           1, qscf_pkg::SH3, 3, t, sat);
    r.coef4 = fit_quotient(fit_numerator(3 * a1 - 2 * a2, 14 * v2 + 16 * v1, 30 * (p1 - p2), t),
                           0, qscf_pkg::SH4, 4, t, sat);
    r.coef5 = fit_quotient(fit_numerator(a1 - a2, 6 * v2 + 6 * v1, 12 * (p1 - p2), t),
                           1, qscf_pkg::SH5, 5, t, sat);
    r.saturated = sat;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    qscf_pkg::seg_out_t want;
    if (rst) begin
      min_interval <= '0;
      coef_queue.delete();
      errors = 0;
      pending = 0;
      n_segments = 0;
      n_invalid = 0;
      n_saturated = 0;
    end else begin
      if (cfg_we) min_interval <= cfg_data;
      if (in_valid && in_ready) begin
        want = fit_segment(in_data, min_interval);
        coef_queue = {coef_queue, want};
        n_segments++;
        if (want.interval_invalid) n_invalid++;
        if (want.saturated) n_saturated++;
      end
      if (out_valid && out_ready) begin
        if (coef_queue.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h", $time, out_data);
          errors++;
        end else begin
          want = coef_queue.pop_front();
          check_field("coef0", want.coef0, out_data.coef0);
          check_field("coef1", want.coef1, out_data.coef1);
          check_field("coef2", want.coef2, out_data.coef2);
          check_field("coef3", want.coef3, out_data.coef3);
          check_field("coef4", want.coef4, out_data.coef4);
          check_field("coef5", want.coef5, out_data.coef5);
          check_field("interval_invalid", want.interval_invalid, out_data.interval_invalid);
          check_field("saturated", want.saturated, out_data.saturated);
        end
      end
      pending = coef_queue.size();
    end
  end

endmodule

>>> bench/tb_quintic_segment_coefficient_fit_unit.sv
// tb_quintic_segment_coefficient_fit_unit: drives segments and min_interval settings into
// the quintic fit unit with random gaps and stalls; the checker predicts and compares
// depends on qscf_pkg, qscf_fit_checker and the unit under test
`timescale 1ns / 100ps

module tb_quintic_segment_coefficient_fit_unit;

  localparam int PIPE_WAIT   = 100;    // beyond the pipeline latency
  localparam int IDLE_LIMIT  = 5000;   // cycles with no transfer before giving up
  localparam int PHASE_ITEMS = 400;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_ready;
  qscf_pkg::seg_in_t            in_data;
  logic                         out_valid;
  logic                         out_ready;
  qscf_pkg::seg_out_t           out_data;
  logic                         cfg_we;
  logic [qscf_pkg::MIN_W-1:0]   cfg_data;
  int                 errors, pending, n_segments, n_invalid, n_saturated;
  int                 idle_cycles;
  int                 stall_left;      // cycles left in a long output stall
  bit                 free_flow;       // stretch with no output stalls

  quintic_segment_coefficient_fit_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  qscf_fit_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .n_segments(n_segments),
    .n_invalid(n_invalid), .n_saturated(n_saturated)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // output side stalls, with stretches of always-ready
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 0;
      free_flow <= 0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(199) == 0) free_flow <= !free_flow;
      if (stall_left > 0) begin
        out_ready <= 0;
        stall_left <= stall_left - 1;
      end else if (free_flow) out_ready <= 1;
      else if ($urandom_range(99) < 3) begin
        out_ready <= 0;                                  // start of a long stall
        stall_left <= $urandom_range(40, 10);
      end else out_ready <= ($urandom_range(99) < 70);
    end
  end

  // watchdog: no transfer on either channel for too long
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("quintic_segment_coefficient_fit_unit: mismatch");
        $finish;
      end
    end
  end

  // one segment transfer; called and returning at a falling edge
  task automatic send_segment(qscf_pkg::seg_in_t s);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_field();
    case ($urandom_range(5))
      0: return $urandom_range(255);                        // tiny positive
      1: return -$urandom_range(255);                       // tiny negative
      2: return $urandom_range(32'h0004_0000) - 32'h0002_0000;  // around +-2.0
      default: return $urandom;
    endcase
  endfunction

  function automatic qscf_pkg::seg_in_t rand_segment(logic [qscf_pkg::MIN_W-1:0] min_iv);
    qscf_pkg::seg_in_t s;
    s.start_pos = rand_field(); s.start_vel = rand_field(); s.start_acc = rand_field();
    s.end_pos   = rand_field(); s.end_vel   = rand_field(); s.end_acc   = rand_field();
    case ($urandom_range(7))
      0: s.duration = $urandom;
      1: s.duration = $urandom_range(32'h0001_FFFF);             // near and below the limit
      2: s.duration = {16'b0, min_iv} + $urandom_range(2);       // right at the threshold
      3: s.duration = $urandom_range(32'h0000_FFFF, 32'h0000_0100); // short: saturating
      default: s.duration = $urandom_range(32'h0100_0000, 32'h0000_4000); // 0.25 .. 256
    endcase
    return s;
  endfunction

  // min_interval changes only with the pipeline empty
  task automatic set_min_interval(logic [qscf_pkg::MIN_W-1:0] v);
    int spin;
    in_valid <= 0;
    spin = 0;
    while (pending != 0 && spin < IDLE_LIMIT) begin
      @(negedge clk);
      spin++;
    end
    repeat (PIPE_WAIT) @(negedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic run_phase(logic [qscf_pkg::MIN_W-1:0] min_iv, bit extremes);
    qscf_pkg::seg_in_t s;
    set_min_interval(min_iv);
    // threshold edges
    s = '{default: 32'h0001_0000};
    s.duration = 0;                     send_segment(s);
    s.duration = {16'b0, min_iv};       send_segment(s);
    s.duration = {16'b0, min_iv} + 1;   send_segment(s);
    s.duration = 32'hFFFF_FFFF;         send_segment(s);
    if (extremes) begin
      s = '{default: 32'h7FFF_FFFF};
      s.duration = 1;                   send_segment(s);     // positive extremes, shortest
      s = '{default: 32'h8000_0000};
      s.duration = 32'hFFFF_FFFF;       send_segment(s);     // negative extremes, longest
      s.duration = 1;                   send_segment(s);
      s = '0;
      s.duration = 32'h0001_0000;       send_segment(s);     // all zero boundary values
      s.start_pos = 32'h7FFF_FFFF; s.end_pos = 32'h8000_0000;
      s.duration = 2;                   send_segment(s);     // overflow of every term
      s = '{default: 32'hFFFF_FFFF};
      s.duration = 32'h8000_0000;       send_segment(s);
    end
    repeat (PHASE_ITEMS) send_segment(rand_segment(min_iv));
  endtask

  initial begin
    int spin;
    rst = 1;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    run_phase(16'h0000, 1);
    run_phase(16'hFFFF, 0);
    run_phase(16'h0100, 0);
    run_phase(16'($urandom), 0);
    run_phase(16'h0001, 0);
    in_valid <= 0;

    spin = 0;
    while (pending != 0 && spin < IDLE_LIMIT) begin
      @(posedge clk);
      spin++;
    end
    repeat (PIPE_WAIT) @(posedge clk);

    $display("covered %0d segments over five min_interval settings (0, max, and others)",
             n_segments);
    $display("of those %0d rejected as too short and %0d with clipped coefficients",
             n_invalid, n_saturated);
    if (errors == 0 && pending == 0) begin
      $display("quintic_segment_coefficient_fit_unit: match");
    end else begin
      $display("quintic_segment_coefficient_fit_unit: mismatch");
    end
    $finish;
  end

endmodule
